// ===== hw/rtl/lh_pkg.sv =====
package lh_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int COUNT_WIDTH = 64;
    localparam int NUM_BINS    = VALUE_WIDTH + 1;
    localparam int BIN_W       = $clog2(NUM_BINS);

    localparam int OP_W        = 2;
    localparam int SAMPLE_W    = 64;
    localparam int SEL_W       = 7;
    localparam int COUNT_OUT_W = 64;

    typedef enum logic [OP_W-1:0] {
        OP_RECORD = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef struct packed {
        logic                   clear;
        logic                   rd_en;
        logic [BIN_W-1:0]       rd_addr;
        logic                   wr_en;
        logic [BIN_W-1:0]       wr_addr;
        logic [COUNT_WIDTH-1:0] wr_data;
    } t_mem_req;

endpackage

// ===== hw/rtl/log2_histogram.sv =====
// Power-of-two histogram: VALUE_WIDTH+1 bins of COUNT_WIDTH-bit wrapping
// counters held in a one-port-read, one-port-write synchronous memory. Each
// item (record, read or clear) passes through the steps capture, bin encode,
// memory read, then update and write-back into the output register. The
// input takes no new item until the last one has left the update step, which
// waits while the output is stalled; the next item is accepted while a result
// still waits in the output register. Clear zeroes all bins at once through
// per-bin valid bits, so no clearing pass is needed after reset.
module log2_histogram (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [lh_pkg::OP_W-1:0]        i_op,
    input  logic [lh_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic [lh_pkg::SEL_W-1:0]       i_bin_select,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [lh_pkg::SEL_W-1:0]       o_bin,
    output logic [lh_pkg::COUNT_OUT_W-1:0] o_count
);
    import lh_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_BIN  = 4'b0010,
        S_READ = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state                 r_state, n_state;
    t_op                    r_op;
    logic [VALUE_WIDTH-1:0] r_sample;
    logic [SEL_W-1:0]       r_sel;
    logic [BIN_W-1:0]       r_addr;
    logic [SEL_W-1:0]       r_res_bin;
    logic                   r_hit;
    logic                   r_out_valid;
    logic [SEL_W-1:0]       r_out_bin;
    logic [COUNT_WIDTH-1:0] r_out_count;

    logic [BIN_W-1:0]       enc_bin;
    logic [COUNT_WIDTH-1:0] rd_data;
    logic [COUNT_WIDTH-1:0] new_count;
    logic                   in_acc;
    logic                   sel_ok;
    logic                   load_out;
    t_mem_req               mem_req;

    lh_bin_enc u_enc (
        .i_value (r_sample),
        .o_bin   (enc_bin)
    );

    lh_count_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign sel_ok   = (r_sel < SEL_W'(NUM_BINS));
    assign load_out = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        case (r_op)
            OP_RECORD: new_count = rd_data + COUNT_WIDTH'(1);
            OP_READ:   new_count = r_hit ? rd_data : '0;
            default:   new_count = '0;
        endcase
    end

    always_comb begin
        mem_req         = '0;
        mem_req.clear   = (r_state == S_BIN) && (r_op == OP_CLEAR);
        mem_req.rd_en   = (r_state == S_READ);
        mem_req.rd_addr = r_addr;
        mem_req.wr_en   = load_out && (r_op == OP_RECORD);
        mem_req.wr_addr = r_addr;
        mem_req.wr_data = new_count;
    end

    always_comb begin
        case (r_state)
            S_IDLE:  n_state = in_acc ? S_BIN : S_IDLE;
            S_BIN:   n_state = S_READ;
            S_READ:  n_state = S_DONE;
            S_DONE:  n_state = load_out ? S_IDLE : S_DONE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op     <= t_op'(i_op);
            r_sample <= i_sample[VALUE_WIDTH-1:0];
            r_sel    <= i_bin_select;
        end
        if (r_state == S_BIN) begin
            case (r_op)
                OP_RECORD: begin
                    r_addr    <= enc_bin;
                    r_res_bin <= SEL_W'(enc_bin);
                    r_hit     <= 1'b1;
                end
                OP_READ: begin
                    r_addr    <= sel_ok ? r_sel[BIN_W-1:0] : '0;
                    r_res_bin <= r_sel;
                    r_hit     <= sel_ok;
                end
                default: begin
                    r_addr    <= '0;
                    r_res_bin <= '0;
                    r_hit     <= 1'b0;
                end
            endcase
        end
        if (load_out) begin
            r_out_bin   <= r_res_bin;
            r_out_count <= new_count;
        end
    end

    assign o_valid = r_out_valid;
    assign o_bin   = r_out_bin;
    assign o_count = COUNT_OUT_W'(r_out_count);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_stall)
        else $error("input not held off after accepting an item");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared outside the update step");

    a_no_clear_and_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.clear && mem_req.wr_en))
        else $error("bin clear collides with counter write");

endmodule

// ===== hw/rtl/lh_bin_enc.sv =====
module lh_bin_enc (
    input  logic [lh_pkg::VALUE_WIDTH-1:0] i_value,
    output logic [lh_pkg::BIN_W-1:0]       o_bin
);
    import lh_pkg::*;

    // highest set bit plus one, zero for a zero value
    always_comb begin
        o_bin = '0;
        for (int i = 0; i < VALUE_WIDTH; i++) begin
            if (i_value[i]) begin
                o_bin = BIN_W'(i + 1);
            end
        end
    end

endmodule

// ===== hw/rtl/lh_count_mem.sv =====
module lh_count_mem (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lh_pkg::t_mem_req               i_req,
    output logic [lh_pkg::COUNT_WIDTH-1:0] o_rd_data
);
    import lh_pkg::*;

    logic [COUNT_WIDTH-1:0] r_mem [NUM_BINS];
    logic [NUM_BINS-1:0]    r_valid;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // per-bin valid bits: clear empties every bin at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_req.rd_en) begin
                r_rd_valid <= r_valid[i_req.rd_addr];
            end
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_addr] <= 1'b1;
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule
